// ----- design/hbi_pkg.sv -----
// ----------------------------------------------------------------------------
// hbi_pkg: shared types and constants for the halfband 2x interpolator
// coefficient register set, register indexes, fixed filter geometry
// ----------------------------------------------------------------------------
`default_nettype none

package hbi_pkg;

    localparam int COEF_W     = 16;
    localparam int NUM_REGS   = 8;
    localparam int NUM_PAIRS  = 7;
    localparam int HIST_DEPTH = 14;
    localparam int CENTER_TAP = 6;
    localparam int OUT_SHIFT  = 15;

    // result buffer in the back part, in sample pairs
    localparam int OBUF_DEPTH = 4;

    // apb geometry
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER5 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEF_INNER  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COEF_CENTER = 3'd7;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NUM_REGS-1:0] t_coef_set;

    localparam t_coef_set COEF_RESET = {
        t_coef'(32767),   // coef_center
        t_coef'(20503),   // coef_inner
        t_coef'(-5942),   // coef_outer5
        t_coef'(2674),    // coef_outer4
        t_coef'(-1214),   // coef_outer3
        t_coef'(491),     // coef_outer2
        t_coef'(-158),    // coef_outer1
        t_coef'(33)       // coef_outer0
    };

endpackage

`default_nettype wire

// ----- design/hbi_front.sv -----
// ----------------------------------------------------------------------------
// hbi_front: input side of the halfband interpolator
// takes samples into the delay line and forms the folded pair sums
// ----------------------------------------------------------------------------
`default_nettype none

module hbi_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_valid,
    output logic                                                o_stall,
    input  wire logic [SAMPLE_WIDTH-1:0]                        i_in_real,
    input  wire logic [SAMPLE_WIDTH-1:0]                        i_in_imag,
    output logic                                                o_push,
    input  wire logic                                           i_full,
    output logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0]       o_sum_re,
    output logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0]       o_sum_im,
    output logic [SAMPLE_WIDTH-1:0]                             o_ctr_re,
    output logic [SAMPLE_WIDTH-1:0]                             o_ctr_im
);

    localparam int SUM_W = SAMPLE_WIDTH + 1;

    logic [SAMPLE_WIDTH-1:0] r_hist_re [hbi_pkg::HIST_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_hist_im [hbi_pkg::HIST_DEPTH];
    logic                    r_pend;
    logic                    w_accept;

    // a window waits in r_pend until the queue takes it
    assign o_push   = r_pend && !i_full;
    assign o_stall  = r_pend && i_full;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            for (int k = 0; k < hbi_pkg::HIST_DEPTH; k++) begin
                r_hist_re[k] <= '0;
                r_hist_im[k] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_pend       <= 1'b1;
                r_hist_re[0] <= i_in_real;
                r_hist_im[0] <= i_in_imag;
                for (int k = 1; k < hbi_pkg::HIST_DEPTH; k++) begin
                    r_hist_re[k] <= r_hist_re[k-1];
                    r_hist_im[k] <= r_hist_im[k-1];
                end
            end else if (o_push) begin
                r_pend <= 1'b0;
            end
        end
    end

    // fold the window: tap k pairs with tap 13-k
    for (genvar g = 0; g < hbi_pkg::NUM_PAIRS; g++) begin : g_fold
        assign o_sum_re[g] = SUM_W'($signed(r_hist_re[g]))
                           + SUM_W'($signed(r_hist_re[hbi_pkg::HIST_DEPTH-1-g]));
        assign o_sum_im[g] = SUM_W'($signed(r_hist_im[g]))
                           + SUM_W'($signed(r_hist_im[hbi_pkg::HIST_DEPTH-1-g]));
    end

    assign o_ctr_re = r_hist_re[hbi_pkg::CENTER_TAP];
    assign o_ctr_im = r_hist_im[hbi_pkg::CENTER_TAP];

endmodule

`default_nettype wire

// ----- design/hbi_queue.sv -----
// ----------------------------------------------------------------------------
// hbi_queue: small fifo between the front and back parts
// holds folded windows so either side can stall on its own
// ----------------------------------------------------------------------------
`default_nettype none

module hbi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/hbi_back.sv -----
// ----------------------------------------------------------------------------
// hbi_back: multiply, sum, round and emit for the halfband interpolator
// multiplier lanes, registered adder tree, result buffer, output register
// ----------------------------------------------------------------------------
`default_nettype none

module hbi_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire hbi_pkg::t_coef_set                             i_coef,
    input  wire logic                                           i_empty,
    output logic                                                o_pop,
    input  wire logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0]  i_sum_re,
    input  wire logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0]  i_sum_im,
    input  wire logic [SAMPLE_WIDTH-1:0]                        i_ctr_re,
    input  wire logic [SAMPLE_WIDTH-1:0]                        i_ctr_im,
    output logic                                                o_valid,
    input  wire logic                                           i_stall,
    output logic [SAMPLE_WIDTH-1:0]                             o_out_real,
    output logic [SAMPLE_WIDTH-1:0]                             o_out_imag,
    output logic                                                o_phase_last
);

    localparam int SUM_W   = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = SUM_W + hbi_pkg::COEF_W;
    localparam int CPROD_W = SAMPLE_WIDTH + hbi_pkg::COEF_W;
    localparam int PART_W  = PROD_W + 2;
    localparam int ACC_W   = PROD_W + 3;
    localparam int TOP_W   = ACC_W - hbi_pkg::OUT_SHIFT - SAMPLE_WIDTH + 2;
    localparam int OCNT_W  = $clog2(hbi_pkg::OBUF_DEPTH + 1);
    localparam int USED_W  = OCNT_W + 1;
    localparam int OPTR_W  = $clog2(hbi_pkg::OBUF_DEPTH);
    localparam int OENT_W  = 4 * SAMPLE_WIDTH;
    localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1) << (hbi_pkg::OUT_SHIFT - 1);

    // round half up, floor shift, saturate
    function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] x;
        logic [TOP_W-1:0]      top;
        x   = $signed({acc[ACC_W-1], acc}) + RND_BIAS;
        top = x[ACC_W:hbi_pkg::OUT_SHIFT+SAMPLE_WIDTH-1];
        if ((&top) || !(|top)) begin
            return x[hbi_pkg::OUT_SHIFT+SAMPLE_WIDTH-1:hbi_pkg::OUT_SHIFT];
        end
        if (x[ACC_W]) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

    // stage 1: products
    logic                      r_v1;
    logic signed [PROD_W-1:0]  r_p_re [hbi_pkg::NUM_PAIRS];
    logic signed [PROD_W-1:0]  r_p_im [hbi_pkg::NUM_PAIRS];
    logic signed [CPROD_W-1:0] r_pc_re;
    logic signed [CPROD_W-1:0] r_pc_im;
    // stage 2: partial sums
    logic                      r_v2;
    logic signed [PART_W-1:0]  r_a_re;
    logic signed [PART_W-1:0]  r_b_re;
    logic signed [PART_W-1:0]  r_a_im;
    logic signed [PART_W-1:0]  r_b_im;
    logic signed [CPROD_W-1:0] r_c2_re;
    logic signed [CPROD_W-1:0] r_c2_im;
    // stage 3: full sums
    logic                      r_v3;
    logic signed [ACC_W-1:0]   r_acc_re;
    logic signed [ACC_W-1:0]   r_acc_im;
    logic signed [CPROD_W-1:0] r_c3_re;
    logic signed [CPROD_W-1:0] r_c3_im;
    // result buffer and output register
    logic [OENT_W-1:0]         r_ob [hbi_pkg::OBUF_DEPTH];
    logic [OPTR_W-1:0]         r_owp;
    logic [OPTR_W-1:0]         r_orp;
    logic [OCNT_W-1:0]         r_ocnt;
    logic                      r_half;
    logic                      r_ovalid;
    logic [SAMPLE_WIDTH-1:0]   r_out_re;
    logic [SAMPLE_WIDTH-1:0]   r_out_im;
    logic                      r_out_ph;

    logic [USED_W-1:0]         w_used;
    logic                      w_load;
    logic                      w_opop;
    logic [OENT_W-1:0]         w_head;

    // reserve buffer room for everything in flight before issuing
    assign w_used = USED_W'(r_v1) + USED_W'(r_v2) + USED_W'(r_v3) + USED_W'(r_ocnt);
    assign o_pop  = !i_empty && (w_used < USED_W'(hbi_pkg::OBUF_DEPTH));

    for (genvar g = 0; g < hbi_pkg::NUM_PAIRS; g++) begin : g_lane
        logic signed [PROD_W-1:0] w_p_re;
        logic signed [PROD_W-1:0] w_p_im;
        assign w_p_re = $signed(i_sum_re[g]) * $signed(i_coef[g]);
        assign w_p_im = $signed(i_sum_im[g]) * $signed(i_coef[g]);
        always_ff @(posedge i_clk) begin
            r_p_re[g] <= w_p_re;
            r_p_im[g] <= w_p_im;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc_re  <= $signed(i_ctr_re) * $signed(i_coef[hbi_pkg::REG_COEF_CENTER]);
        r_pc_im  <= $signed(i_ctr_im) * $signed(i_coef[hbi_pkg::REG_COEF_CENTER]);

        r_a_re   <= PART_W'(r_p_re[0]) + PART_W'(r_p_re[1])
                  + PART_W'(r_p_re[2]) + PART_W'(r_p_re[3]);
        r_b_re   <= PART_W'(r_p_re[4]) + PART_W'(r_p_re[5]) + PART_W'(r_p_re[6]);
        r_a_im   <= PART_W'(r_p_im[0]) + PART_W'(r_p_im[1])
                  + PART_W'(r_p_im[2]) + PART_W'(r_p_im[3]);
        r_b_im   <= PART_W'(r_p_im[4]) + PART_W'(r_p_im[5]) + PART_W'(r_p_im[6]);
        r_c2_re  <= r_pc_re;
        r_c2_im  <= r_pc_im;

        r_acc_re <= ACC_W'(r_a_re) + ACC_W'(r_b_re);
        r_acc_im <= ACC_W'(r_a_im) + ACC_W'(r_b_im);
        r_c3_re  <= r_c2_re;
        r_c3_im  <= r_c2_im;

        if (r_v3) begin
            r_ob[r_owp] <= {round_sat(r_acc_re), round_sat(r_acc_im),
                            round_sat(ACC_W'(r_c3_re)), round_sat(ACC_W'(r_c3_im))};
        end
    end

    // head entry: even re, even im, odd re, odd im
    assign w_head = r_ob[r_orp];
    assign w_load = (r_ocnt != '0) && (!r_ovalid || !i_stall);
    assign w_opop = w_load && r_half;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (!r_half) begin
                r_out_re <= w_head[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];
                r_out_im <= w_head[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
                r_out_ph <= 1'b0;
            end else begin
                r_out_re <= w_head[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
                r_out_im <= w_head[SAMPLE_WIDTH-1:0];
                r_out_ph <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
            r_half   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_owp <= r_owp + OPTR_W'(1);
            end
            if (w_opop) begin
                r_orp <= r_orp + OPTR_W'(1);
            end
            r_ocnt <= r_ocnt + OCNT_W'(r_v3) - OCNT_W'(w_opop);
            if (w_load) begin
                r_half   <= !r_half;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_real   = r_out_re;
    assign o_out_imag   = r_out_im;
    assign o_phase_last = r_out_ph;

endmodule

`default_nettype wire

// ----- design/halfband_fir_interpolator_2x.sv -----
// ----------------------------------------------------------------------------
// halfband_fir_interpolator_2x: 27-tap halfband 2x interpolator, complex int16
// path: delay line, queue, product, partial and full sum stages, result buffer,
//   output register; the second result follows the first unless the output stalls
// throughput: two results per input, one result per cycle while the output is
//   not stalled, so the single result channel sets the sustained input rate
// reset: synchronous active low; clears the delay line, queue and pipeline and
//   loads the default coefficients
// ----------------------------------------------------------------------------
`default_nettype none

module halfband_fir_interpolator_2x #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // apb configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [hbi_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [hbi_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hbi_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    // input sample channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [SAMPLE_WIDTH-1:0]            i_in_real,
    input  wire logic [SAMPLE_WIDTH-1:0]            i_in_imag,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [SAMPLE_WIDTH-1:0]                 o_out_real,
    output logic [SAMPLE_WIDTH-1:0]                 o_out_imag,
    output logic                                    o_phase_last
);

    // queue entry: seven folded sums per component plus the center sample
    localparam int SUM_W = SAMPLE_WIDTH + 1;
    localparam int ENT_W = 2 * hbi_pkg::NUM_PAIRS * SUM_W + 2 * SAMPLE_WIDTH;

    hbi_pkg::t_coef_set r_coef;

    logic [hbi_pkg::REG_IDX_W-1:0]                 w_idx;
    logic                                          w_wr;
    hbi_pkg::t_coef                                w_rd_coef;

    logic                                          f_push;
    logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0] f_sum_re;
    logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0] f_sum_im;
    logic [SAMPLE_WIDTH-1:0]                       f_ctr_re;
    logic [SAMPLE_WIDTH-1:0]                       f_ctr_im;

    logic                                          q_full;
    logic                                          q_empty;
    logic                                          q_pop;
    logic [ENT_W-1:0]                              q_wdata;
    logic [ENT_W-1:0]                              q_rdata;

    logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0] b_sum_re;
    logic [hbi_pkg::NUM_PAIRS-1:0][SAMPLE_WIDTH:0] b_sum_im;
    logic [SAMPLE_WIDTH-1:0]                       b_ctr_re;
    logic [SAMPLE_WIDTH-1:0]                       b_ctr_im;

    // ------------------------------------------------------------------
    // coefficient registers, one per word; every address decodes to one
    // of the eight registers, so there is no unmapped space
    // ------------------------------------------------------------------
    assign w_idx  = paddr[hbi_pkg::APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= hbi_pkg::COEF_RESET;
        end else if (w_wr) begin
            r_coef[w_idx] <= pwdata[hbi_pkg::COEF_W-1:0];
        end
    end

    // reads return the coefficient sign extended to the bus width
    assign w_rd_coef = r_coef[w_idx];
    assign prdata    = {{(hbi_pkg::APB_DATA_W-hbi_pkg::COEF_W){w_rd_coef[hbi_pkg::COEF_W-1]}},
                        w_rd_coef};

    // ------------------------------------------------------------------
    // front: delay line and folding, one window per accepted request
    // ------------------------------------------------------------------
    hbi_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_real (i_in_real),
        .i_in_imag (i_in_imag),
        .o_push    (f_push),
        .i_full    (q_full),
        .o_sum_re  (f_sum_re),
        .o_sum_im  (f_sum_im),
        .o_ctr_re  (f_ctr_re),
        .o_ctr_im  (f_ctr_im)
    );

    // ------------------------------------------------------------------
    // decoupling queue: lets the front keep taking samples in a burst
    // while the back part, unless the output stalls, drains results at one per cycle
    // ------------------------------------------------------------------
    assign q_wdata = {f_sum_re, f_sum_im, f_ctr_re, f_ctr_im};

    hbi_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_sum_re, b_sum_im, b_ctr_re, b_ctr_im} = q_rdata;

    // ------------------------------------------------------------------
    // back: multiplier lanes, adder tree, rounding and saturation, then
    // the even phase result followed by the center tap result
    // ------------------------------------------------------------------
    hbi_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coef       (r_coef),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .i_sum_re     (b_sum_re),
        .i_sum_im     (b_sum_im),
        .i_ctr_re     (b_ctr_re),
        .i_ctr_im     (b_ctr_im),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_real   (o_out_real),
        .o_out_imag   (o_out_imag),
        .o_phase_last (o_phase_last)
    );

endmodule

`default_nettype wire

// ----- design/hbi_checker.sv -----
// ----------------------------------------------------------------------------
// hbi_checker: port level checks for the halfband 2x interpolator
// result pairing, stall hold and reset behavior
// ----------------------------------------------------------------------------
`default_nettype none

module hbi_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [SAMPLE_WIDTH-1:0]        o_out_real,
    input wire logic [SAMPLE_WIDTH-1:0]        o_out_imag,
    input wire logic                           o_phase_last
);

    // the center tap result follows its folded result right away
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_phase_last) |=> (o_valid && o_phase_last))
        else $error("center tap result did not follow folded result");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_real)
            && $stable(o_out_imag) && $stable(o_phase_last)))
        else $error("stalled result changed");

    // reset empties the result side
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // reset leaves the input side ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind halfband_fir_interpolator_2x hbi_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_hbi_checker (.*);

`default_nettype wire

// ----- tb/sv/halfband_interp_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_interp_monitor: result checker for the 2x halfband interpolator
// Watches the coefficient port and both sample channels. Keeps a copy of the
// delay line and coefficients, works out the folded-sum and center-tap
// results of every accepted sample, and compares them in order with the
// accepted results. Register reads are checked against the copied values.
// ----------------------------------------------------------------------------
module halfband_interp_monitor #(
    parameter int SW = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [hbi_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [hbi_pkg::APB_DATA_W-1:0] i_pwdata,
    input  wire logic [hbi_pkg::APB_DATA_W-1:0] i_prdata,
    input  wire logic                           i_pready,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic [SW-1:0]                  i_in_real,
    input  wire logic [SW-1:0]                  i_in_imag,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [SW-1:0]                  i_out_real,
    input  wire logic [SW-1:0]                  i_out_imag,
    input  wire logic                           i_out_last,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked
);

    typedef struct packed {
        logic [SW-1:0] re;
        logic [SW-1:0] im;
        logic          last;
    } t_interp_out;

    t_interp_out          expected_outputs[$];
    hbi_pkg::t_coef_set   coefs;
    logic signed [SW-1:0] hist_re [hbi_pkg::HIST_DEPTH];
    logic signed [SW-1:0] hist_im [hbi_pkg::HIST_DEPTH];

    int errors = 0;
    int checked = 0;
    int pending_cnt = 0;

    assign o_errors  = errors;
    assign o_pending = pending_cnt;
    assign o_checked = checked;

    // round half up, floor shift, clip to the sample range
    function automatic logic [SW-1:0] round_clip(input longint acc);
        longint q;
        longint top_v = (longint'(1) <<< (SW - 1)) - 1;
        q = (acc + (longint'(1) <<< (hbi_pkg::OUT_SHIFT - 1))) >>> hbi_pkg::OUT_SHIFT;
        if (q > top_v)
            q = top_v;
        else if (q < -top_v - 1)
            q = -top_v - 1;
        return q[SW-1:0];
    endfunction

    function automatic longint folded_acc(input bit imag_side);
        longint acc = 0;
        longint a;
        longint b;
        for (int k = 0; k < hbi_pkg::NUM_PAIRS; k++) begin
            a = imag_side ? hist_im[k] : hist_re[k];
            b = imag_side ? hist_im[hbi_pkg::HIST_DEPTH-1-k]
                          : hist_re[hbi_pkg::HIST_DEPTH-1-k];
            acc += longint'($signed(coefs[k])) * (a + b);
        end
        return acc;
    endfunction

    task automatic interpolate_sample(input logic [SW-1:0] re, input logic [SW-1:0] im);
        t_interp_out even_o;
        t_interp_out odd_o;
        longint center_c;
        for (int k = hbi_pkg::HIST_DEPTH - 1; k > 0; k--) begin
            hist_re[k] = hist_re[k-1];
            hist_im[k] = hist_im[k-1];
        end
        hist_re[0] = re;
        hist_im[0] = im;
        center_c = longint'($signed(coefs[hbi_pkg::REG_COEF_CENTER]));
        even_o.re   = round_clip(folded_acc(1'b0));
        even_o.im   = round_clip(folded_acc(1'b1));
        even_o.last = 1'b0;
        odd_o.re    = round_clip(center_c * longint'(hist_re[hbi_pkg::CENTER_TAP]));
        odd_o.im    = round_clip(center_c * longint'(hist_im[hbi_pkg::CENTER_TAP]));
        odd_o.last  = 1'b1;
        expected_outputs.push_back(even_o);
        expected_outputs.push_back(odd_o);
        pending_cnt += 2;
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_interp_out exp_o;
        logic [hbi_pkg::REG_IDX_W-1:0] idx;
        idx = i_paddr[hbi_pkg::APB_ADDR_W-1:2];
        if (!i_rst_n) begin
            coefs = hbi_pkg::COEF_RESET;
            for (int k = 0; k < hbi_pkg::HIST_DEPTH; k++) begin
                hist_re[k] = '0;
                hist_im[k] = '0;
            end
            expected_outputs.delete();
            pending_cnt = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite)
                    coefs[idx] = i_pwdata[hbi_pkg::COEF_W-1:0];
                else if (i_prdata[hbi_pkg::COEF_W-1:0] !== coefs[idx])
                    note_mismatch($sformatf("register %0d read %h, holds %h",
                                            idx, i_prdata[hbi_pkg::COEF_W-1:0],
                                            coefs[idx]));
            end
            if (i_in_valid && !i_in_stall)
                interpolate_sample(i_in_real, i_in_imag);
            if (i_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    note_mismatch($sformatf("result %h/%h/%b with no sample waiting",
                                            i_out_real, i_out_imag, i_out_last));
                end else begin
                    exp_o = expected_outputs.pop_front();
                    pending_cnt--;
                    checked++;
                    if (i_out_real !== exp_o.re)
                        note_mismatch($sformatf("result %0d real %h, want %h",
                                                checked, i_out_real, exp_o.re));
                    if (i_out_imag !== exp_o.im)
                        note_mismatch($sformatf("result %0d imag %h, want %h",
                                                checked, i_out_imag, exp_o.im));
                    if (i_out_last !== exp_o.last)
                        note_mismatch($sformatf("result %0d phase %b, want %b",
                                                checked, i_out_last, exp_o.last));
                end
            end
        end
    end

endmodule

// ----- tb/sv/halfband_fir_interpolator_2x_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfband_fir_interpolator_2x_test: bench top for the 2x halfband interpolator
// Drives complex samples and coefficient writes, varies source gaps and sink
// stalls, and leaves all result checking to the monitor beside the block.
// ----------------------------------------------------------------------------
module halfband_fir_interpolator_2x_test;

    localparam int SW            = 16;
    localparam int HOLD_CYCLES   = 120;  // long sink hold-off, fills the block
    localparam int ITEMS_PER_MIX = 50;   // flow mix changes every this many requests
    localparam int TAIL_CYCLES   = 20;   // quiet tail at the end of the run

    // flow-control mixes for the two channels
    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } t_flow;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [hbi_pkg::APB_ADDR_W-1:0] paddr;
    logic [hbi_pkg::APB_DATA_W-1:0] pwdata;
    logic [hbi_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [SW-1:0]                  in_real;
    logic [SW-1:0]                  in_imag;
    logic                           out_valid;
    logic                           out_stall;
    logic [SW-1:0]                  out_real;
    logic [SW-1:0]                  out_imag;
    logic                           out_last;

    int fail_count;
    int pending;
    int results_checked;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_asked  = 0;
    int hold_done   = 0;
    int samples_sent = 0;
    int sets_loaded  = 0;

    halfband_fir_interpolator_2x i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_in_real    (in_real),
        .i_in_imag    (in_imag),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_out_real   (out_real),
        .o_out_imag   (out_imag),
        .o_phase_last (out_last)
    );

    halfband_interp_monitor #(.SW(SW)) i_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_real   (in_real),
        .i_in_imag   (in_imag),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_real  (out_real),
        .i_out_imag  (out_imag),
        .i_out_last  (out_last),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_checked   (results_checked)
    );

    // 4 ns clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // safety net: far beyond the slowest correct run
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    // result sink: random stalls per the current mix, plus the long hold-off
    // whenever the stimulus asks for one
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asked != hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done++;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic set_flow(input t_flow mix);
        unique case (mix)
            FLOW_FREE:       begin idle_pct = 0;  stall_pct = 0;  end
            FLOW_SEND_IDLE:  begin idle_pct = 79; stall_pct = 0;  end
            FLOW_RECV_STALL: begin idle_pct = 0;  stall_pct = 79; end
            default:         begin idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    // setup cycle then access cycle; the register takes the value on the
    // access edge. upper data bits are junk on purpose
    task automatic apb_write(input int r, input hbi_pkg::t_coef value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hbi_pkg::APB_ADDR_W'(r * 4);
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read data is checked by the monitor on the access edge
    task automatic apb_read(input int r);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= hbi_pkg::APB_ADDR_W'(r * 4);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only called with the block idle: all results already back
    task automatic load_coefs(input hbi_pkg::t_coef_set c);
        for (int r = hbi_pkg::REG_COEF_OUTER0; r <= hbi_pkg::REG_COEF_CENTER; r++)
            apb_write(r, c[r]);
        for (int r = hbi_pkg::REG_COEF_OUTER0; r <= hbi_pkg::REG_COEF_CENTER; r++)
            apb_read(r);
        sets_loaded++;
    endtask

    // one request: random gap first, then hold valid until accepted.
    // valid stays high after acceptance so back-to-back requests never
    // drop it between them
    task automatic send_sample(input logic [SW-1:0] re, input logic [SW-1:0] im);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_real  <= re;
        in_imag  <= im;
        do @(posedge clk); while (in_stall);
        samples_sent++;
    endtask

    // sender pause: drop valid and wait for every result
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // full-scale corners get extra weight so saturation shows up often
    function automatic logic [SW-1:0] pick_value();
        unique case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // a run of random requests, rotating the flow mix every chunk;
    // the optional hold-off starts with the first request
    task automatic run_mix(input int first_mix, input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (i % ITEMS_PER_MIX == 0)
                set_flow(t_flow'((first_mix + i / ITEMS_PER_MIX) % 4));
            if (with_hold && i == 0)
                hold_asked++;
            send_sample(pick_value(), pick_value());
        end
        wait_drained();
    endtask

    function automatic hbi_pkg::t_coef_set random_coefs();
        hbi_pkg::t_coef_set c;
        for (int r = 0; r < hbi_pkg::NUM_REGS; r++)
            c[r] = hbi_pkg::t_coef'($urandom);
        return c;
    endfunction

    function automatic hbi_pkg::t_coef_set fill_coefs(input hbi_pkg::t_coef even_v,
                                                      input hbi_pkg::t_coef odd_v);
        hbi_pkg::t_coef_set c;
        for (int r = 0; r < hbi_pkg::NUM_REGS; r++)
            c[r] = r[0] ? odd_v : even_v;
        return c;
    endfunction

    initial begin
        // every block input known from time zero
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_real  = '0;
        in_imag  = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients must read back as the defaults
        for (int r = hbi_pkg::REG_COEF_OUTER0; r <= hbi_pkg::REG_COEF_CENTER; r++)
            apb_read(r);

        // directed: a full-scale impulse walks through every tap, then
        // constant full-scale runs push the folded phase into saturation
        set_flow(FLOW_FREE);
        send_sample(16'h7fff, 16'h8000);
        repeat (13) send_sample('0, '0);
        repeat (8) send_sample(16'h7fff, 16'h8000);
        repeat (3) send_sample(16'h8000, 16'h7fff);

        // default coefficients, starts with the long sink hold-off
        run_mix(FLOW_FREE, 150, 1'b1);

        // all coefficients at the positive extreme
        load_coefs(fill_coefs(hbi_pkg::t_coef'(32767), hbi_pkg::t_coef'(32767)));
        run_mix(FLOW_SEND_IDLE, 300, 1'b0);

        // all at the negative extreme: largest accumulator magnitude
        load_coefs(fill_coefs(hbi_pkg::t_coef'(-32768), hbi_pkg::t_coef'(-32768)));
        run_mix(FLOW_RECV_STALL, 300, 1'b0);

        load_coefs(random_coefs());
        run_mix(FLOW_BOTH, 300, 1'b0);

        // alternating extremes, with another hold-off
        load_coefs(fill_coefs(hbi_pkg::t_coef'(32767), hbi_pkg::t_coef'(-32768)));
        run_mix(FLOW_FREE, 300, 1'b1);

        load_coefs(random_coefs());
        run_mix(FLOW_RECV_STALL, 250, 1'b0);

        // back to the defaults by writing them
        load_coefs(hbi_pkg::COEF_RESET);
        run_mix(FLOW_SEND_IDLE, 250, 1'b0);

        // quiet tail so stray results still get caught
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d samples and %0d results over %0d coefficient sets,",
                 samples_sent, results_checked, sets_loaded + 1);
        $display("four flow mixes and %0d long sink hold-offs", hold_done);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hbi_pkg.sv
design/hbi_front.sv
design/hbi_queue.sv
design/hbi_back.sv
design/halfband_fir_interpolator_2x.sv
design/hbi_checker.sv
tb/sv/halfband_interp_monitor.sv
tb/sv/halfband_fir_interpolator_2x_test.sv
